[rtl/present80_ctr_stream_cipher_unit_assert.svh]
// ----------------------------------------------------------------------------
// present80 ctr assertion macros
// shared concurrent assertion forms for the cipher unit
// ----------------------------------------------------------------------------
`ifndef PRESENT80_CTR_STREAM_CIPHER_UNIT_ASSERT_SVH
`define PRESENT80_CTR_STREAM_CIPHER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define P80_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("p80ctr assertion failed");

// next-cycle implication, disabled in reset
`define P80_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("p80ctr assertion failed");

`endif

[rtl/p80ctr_pkg.sv]
// ----------------------------------------------------------------------------
// p80ctr package
// types, constants and round functions of the present80 ctr unit
// ----------------------------------------------------------------------------
`default_nettype none

package p80ctr_pkg;

    localparam int BLOCK_W = 64;
    localparam int KEY_W   = 80;
    localparam int KEY_HI_W = 64;
    localparam int KEY_LO_W = 16;
    localparam int CNT_W   = 4;
    localparam int RND_W   = 5;
    localparam int TDATA_W = 72;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int NUM_BYTES = 8;

    localparam logic [RND_W-1:0] LAST_ROUND = 5'd31;

    localparam logic [3:0] SBOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB,
        4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8,
        4'h4, 4'h7, 4'h1, 4'h2
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_UPPER = 2'd0,
        CFG_KEY_LOWER = 2'd1,
        CFG_INIT_CTR  = 2'd2,
        CFG_UNUSED    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic round;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_round;
    } ctrl_stat_t;

    function automatic logic [BLOCK_W-1:0] sbox_layer(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int n = 0; n < 16; n++)
        begin
            r[n*4 +: 4] = SBOX[x[n*4 +: 4]];
        end
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int i = 0; i < 63; i++)
        begin
            r[(i * 16) % 63] = x[i];
        end
        r[63] = x[63];
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
                                                    input logic [RND_W-1:0] rnd);
        logic [KEY_W-1:0] r;
        r = {k[18:0], k[79:19]};
        r[79:76] = SBOX[r[79:76]];
        r[19:15] = r[19:15] ^ rnd;
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/p80ctr_ctrl.sv]
// ----------------------------------------------------------------------------
// p80ctr controller
// sequences load, 31 rounds and output hand-off of one item at a time
// ----------------------------------------------------------------------------
`default_nettype none

module p80ctr_ctrl
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    input  wire p80ctr_pkg::ctrl_stat_t stat,
    output p80ctr_pkg::ctrl_cmd_t       cmd
);

    p80ctr_pkg::state_t state_reg;
    p80ctr_pkg::state_t state_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            p80ctr_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = p80ctr_pkg::ST_RUN;
                end
            end
            p80ctr_pkg::ST_RUN:
            begin
                if (stat.last_round)
                begin
                    state_next = p80ctr_pkg::ST_DONE;
                end
            end
            p80ctr_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = p80ctr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = p80ctr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            p80ctr_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            p80ctr_pkg::ST_RUN:
            begin
                cmd.round = 1'b1;
            end
            p80ctr_pkg::ST_DONE:
            begin
                cmd.finish = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= p80ctr_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`include "present80_ctr_stream_cipher_unit_assert.svh"

    `P80_ASSERT_NEXT(a_load_starts_run, clk, rst_n, cmd.load, state_reg == p80ctr_pkg::ST_RUN)
    `P80_ASSERT_NEXT(a_last_round_done, clk, rst_n,
                     (state_reg == p80ctr_pkg::ST_RUN) && stat.last_round,
                     state_reg == p80ctr_pkg::ST_DONE)
    `P80_ASSERT_NEXT(a_finish_shows_item, clk, rst_n, cmd.finish, m_tvalid && s_tready)
    `P80_ASSERT_SAME(a_no_finish_over_full, clk, rst_n, cmd.finish && m_tvalid, m_tready)

endmodule

`default_nettype wire

[rtl/p80ctr_datapath.sv]
// ----------------------------------------------------------------------------
// p80ctr datapath
// round unit, on-the-fly key schedule, counter, config and output registers
// ----------------------------------------------------------------------------
`default_nettype none

module p80ctr_datapath
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [p80ctr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [p80ctr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [p80ctr_pkg::BLOCK_W-1:0]      data_in,
    input  wire logic [p80ctr_pkg::CNT_W-1:0]        byte_count,
    output logic      [p80ctr_pkg::BLOCK_W-1:0]      data_out,
    output logic      [p80ctr_pkg::CNT_W-1:0]        byte_count_out,
    input  wire p80ctr_pkg::ctrl_cmd_t               cmd,
    output p80ctr_pkg::ctrl_stat_t                   stat
);

    logic [p80ctr_pkg::KEY_HI_W-1:0] key_upper_reg;
    logic [p80ctr_pkg::KEY_LO_W-1:0] key_lower_reg;
    logic [p80ctr_pkg::BLOCK_W-1:0]  counter_reg;
    logic [p80ctr_pkg::BLOCK_W-1:0]  state_reg;
    logic [p80ctr_pkg::BLOCK_W-1:0]  state_next;
    logic [p80ctr_pkg::KEY_W-1:0]    rkey_reg;
    logic [p80ctr_pkg::KEY_W-1:0]    rkey_next;
    logic [p80ctr_pkg::RND_W-1:0]    rnd_reg;
    logic [p80ctr_pkg::BLOCK_W-1:0]  data_reg;
    logic [p80ctr_pkg::CNT_W-1:0]    cnt_reg;
    logic [p80ctr_pkg::BLOCK_W-1:0]  data_out_reg;
    logic [p80ctr_pkg::CNT_W-1:0]    cnt_out_reg;
    logic [p80ctr_pkg::BLOCK_W-1:0]  keystream;
    logic [p80ctr_pkg::BLOCK_W-1:0]  byte_mask;
    p80ctr_pkg::cfg_index_t          cfg_sel;

    assign cfg_sel = p80ctr_pkg::cfg_index_t'(cfg_index);

    // one present round
    assign state_next = p80ctr_pkg::perm_layer(
                            p80ctr_pkg::sbox_layer(state_reg ^ rkey_reg[79:16]));
    assign rkey_next  = p80ctr_pkg::key_update(rkey_reg, rnd_reg);

    assign stat.last_round = (rnd_reg == p80ctr_pkg::LAST_ROUND);

    // final whitening
    assign keystream = state_reg ^ rkey_reg[79:16];

    // leading bytes kept while their position is below the count
    always_comb
    begin
        for (int j = 0; j < p80ctr_pkg::NUM_BYTES; j++)
        begin
            byte_mask[p80ctr_pkg::BLOCK_W-1-8*j -: 8] =
                {8{cnt_reg > p80ctr_pkg::CNT_W'(j)}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg <= '0;
            key_lower_reg <= '0;
            counter_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_sel)
                    p80ctr_pkg::CFG_KEY_UPPER:
                    begin
                        key_upper_reg <= cfg_data;
                    end
                    p80ctr_pkg::CFG_KEY_LOWER:
                    begin
                        key_lower_reg <= cfg_data[p80ctr_pkg::KEY_LO_W-1:0];
                    end
                    p80ctr_pkg::CFG_INIT_CTR:
                    begin
                        counter_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd.finish && (cnt_reg != '0))
            begin
                counter_reg <= counter_reg + p80ctr_pkg::BLOCK_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            state_reg <= counter_reg;
            rkey_reg  <= {key_upper_reg, key_lower_reg};
            rnd_reg   <= p80ctr_pkg::RND_W'(1);
            data_reg  <= data_in;
            cnt_reg   <= byte_count;
        end
        else if (cmd.round)
        begin
            state_reg <= state_next;
            rkey_reg  <= rkey_next;
            rnd_reg   <= rnd_reg + p80ctr_pkg::RND_W'(1);
        end
        if (cmd.finish)
        begin
            data_out_reg <= (data_reg ^ keystream) & byte_mask;
            cnt_out_reg  <= cnt_reg;
        end
    end

    assign data_out       = data_out_reg;
    assign byte_count_out = cnt_out_reg;

endmodule

`default_nettype wire

[rtl/present80_ctr_stream_cipher_unit.sv]
// ----------------------------------------------------------------------------
// present80 ctr stream cipher unit
// counter-mode present-80 over 64-bit blocks of zero to eight leading bytes
// ----------------------------------------------------------------------------
// One item is worked on at a time. After acceptance it passes through the
// single round unit, whose round key is derived on the fly each cycle, then
// through the final key whitening, the byte mask and the move into the output
// register; the controller then returns to idle, where the next item is taken.
// The move into the output register waits as long as the previous result is
// still held there and not taken. The output register lets a finished result
// wait while the next item is accepted and encrypted. The keystream is the
// encrypted running counter, which advances by one per block with a nonzero
// byte count; writing the initial counter register reloads it. Bytes past the
// count come out zero.
// ----------------------------------------------------------------------------
`default_nettype none

module present80_ctr_stream_cipher_unit
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [p80ctr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [p80ctr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // data_in [63:0], byte_count [67:64], zero [71:68]
    input  wire logic [p80ctr_pkg::TDATA_W-1:0]     s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // data_out [63:0], byte_count_out [67:64], zero [71:68]
    output logic      [p80ctr_pkg::TDATA_W-1:0]     m_tdata
);

    p80ctr_pkg::ctrl_cmd_t             cmd;
    p80ctr_pkg::ctrl_stat_t            stat;
    logic [p80ctr_pkg::BLOCK_W-1:0]    data_out;
    logic [p80ctr_pkg::CNT_W-1:0]      byte_count_out;

    p80ctr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    p80ctr_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .data_in        (s_tdata[p80ctr_pkg::BLOCK_W-1:0]),
        .byte_count     (s_tdata[p80ctr_pkg::BLOCK_W +: p80ctr_pkg::CNT_W]),
        .data_out       (data_out),
        .byte_count_out (byte_count_out),
        .cmd            (cmd),
        .stat           (stat)
    );

    assign m_tdata = {{(p80ctr_pkg::TDATA_W - p80ctr_pkg::BLOCK_W - p80ctr_pkg::CNT_W){1'b0}},
                      byte_count_out, data_out};

endmodule

`default_nettype wire
